### hdl/etp_pkg.sv
// etp_pkg: shared constants, types and tables for the transition probability block
// no dependencies
package etp_pkg;

  localparam int NumStates  = 20;
  localparam int ValueWidth = 32;
  localparam int FracBits   = 24;
  localparam int IdxWidth   = 5;
  localparam int MemDepth   = NumStates * NumStates;
  localparam int AddrWidth  = $clog2(MemDepth);
  localparam int KWidth     = $clog2(NumStates + 1);
  localparam int TolWidth   = 25;
  localparam logic [TolWidth-1:0] TolReset = 25'd168;
  localparam logic signed [31:0] Log2eQ30 = 32'sd1549082005;

  localparam logic [1:0] ActLeft  = 2'd0;
  localparam logic [1:0] ActRight = 2'd1;
  localparam logic [1:0] ActRate  = 2'd2;
  localparam logic [1:0] ActQuery = 2'd3;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatRange = 2'd1;
  localparam logic [1:0] StatNegT  = 2'd2;

  localparam logic signed [63:0] VMax = 64'sd2147483647;
  localparam logic signed [63:0] VMin = -64'sd2147483648;

  // phases of one eigen term through the shared unit
  localparam logic [3:0] PhRead  = 4'd0;
  localparam logic [3:0] PhLr    = 4'd1;
  localparam logic [3:0] PhLt    = 4'd2;
  localparam logic [3:0] PhExpY  = 4'd3;
  localparam logic [3:0] PhExpF  = 4'd4;
  localparam logic [3:0] PhExpSh = 4'd5;
  localparam logic [3:0] PhTe    = 4'd6;
  localparam logic [3:0] PhLam1  = 4'd7;
  localparam logic [3:0] PhLam2  = 4'd8;
  localparam logic [3:0] PhAcc   = 4'd9;

  typedef struct packed {
    logic       clear;
    logic [3:0] phase;
    logic       step;
    logic       finish;
  } etp_cmd_t;

  typedef struct packed {
    logic phase_done;
  } etp_stat_t;

  typedef logic [FracBits:0][31:0] pow_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x, res, b;
    x   = v;
    res = '0;
    b   = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 64'd0) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Q2.30 factors 2^(2^-m), m = 1..24, index 0 = 2.0
  function automatic pow_tab_t calc_pow_tab();
    pow_tab_t tab;
    tab[0] = 32'h8000_0000;
    for (int m = 1; m <= FracBits; m++) tab[m] = 32'(isqrt64(64'(tab[m-1]) << 30));
    return tab;
  endfunction

  localparam pow_tab_t PowTab = calc_pow_tab();

  function automatic logic [31:0] pow_tab(input logic [4:0] m);
    logic [31:0] r;
    r = 32'd1073741824;
    if (m <= 5'd24) r = PowTab[m];
    return r;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > VMax) r = VMax;
    if (v < VMin) r = VMin;
    return r;
  endfunction

endpackage

### hdl/etp_ctrl.sv
// etp_ctrl: sequencer for queries, walks the eigen terms
// depends on etp_pkg
module etp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_fire_i,
  input  logic                 is_query_i,
  input  logic                 out_busy_i,
  input  logic [1:0]           order_i,
  input  etp_pkg::etp_stat_t   stat_i,
  output etp_pkg::etp_cmd_t    cmd_o,
  output logic                 idle_o,
  output logic [etp_pkg::KWidth-1:0] k_o
);
  import etp_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [3:0]        phase_q, phase_d;
  logic [KWidth-1:0] k_q, k_d;
  logic [1:0]        ord_q, ord_d;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    k_d     = k_q;
    ord_d   = ord_q;
    cmd_o   = '0;
    cmd_o.phase = phase_q;
    case (state_q)
      StIdle: begin
        if (in_fire_i && is_query_i) begin
          state_d = StRun;
          phase_d = PhRead;
          k_d     = '0;
          ord_d   = (order_i > 2'd2) ? 2'd2 : order_i;
          cmd_o.clear = 1'b1;
        end
      end
      StRun: begin
        cmd_o.step = 1'b1;
        if (stat_i.phase_done) begin
          case (phase_q)
            PhTe:   phase_d = (ord_q == 2'd0) ? PhAcc : PhLam1;
            PhLam1: phase_d = (ord_q == 2'd1) ? PhAcc : PhLam2;
            PhAcc: begin
              phase_d = PhRead;
              if (k_q == KWidth'(NumStates - 1)) state_d = StOut;
              k_d = k_q + 1'b1;
            end
            default: phase_d = phase_q + 1'b1;
          endcase
        end
      end
      StOut: begin
        if (!out_busy_i) begin
          cmd_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= PhRead;
      k_q     <= '0;
      ord_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      k_q     <= k_d;
      ord_q   <= ord_d;
    end
  end

  assign idle_o = (state_q == StIdle);
  assign k_o    = k_q;
endmodule

### hdl/etp_datapath.sv
// etp_datapath: eigen tables, shared multiplier with exp unit, accumulator
// depends on etp_pkg
module etp_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [1:0]            action_i,
  input  logic [4:0]            row_i,
  input  logic [4:0]            col_i,
  input  logic signed [31:0]    wval_i,
  input  logic signed [31:0]    time_i,
  input  logic [1:0]            order_i,
  input  logic [etp_pkg::TolWidth-1:0] tol_i,
  input  logic [etp_pkg::KWidth-1:0]   k_i,
  input  etp_pkg::etp_cmd_t     cmd_i,
  output etp_pkg::etp_stat_t    stat_o,
  output logic signed [31:0]    res_o,
  output logic [1:0]            status_o
);
  import etp_pkg::*;

  logic signed [31:0] left_mem [MemDepth];
  logic signed [31:0] right_mem [MemDepth];
  logic signed [31:0] rate_mem [NumStates];

  logic [4:0]         qi_q, qj_q;
  logic signed [31:0] qt_q;
  logic [1:0]         qord_q;
  logic               qneg_q, qoor_q;
  logic signed [31:0] lv_q, rv_q, lam_q, term_q, e_q;
  logic signed [31:0] y_q;
  logic [31:0]        acc_q;
  logic [4:0]         m_q;
  logic signed [63:0] sum_q;
  logic signed [31:0] res_q;
  logic [1:0]         status_q;

  logic [AddrWidth-1:0] wr_addr, la, ra;
  assign wr_addr = AddrWidth'(row_i * NumStates + col_i);
  assign la = AddrWidth'(qi_q * NumStates + k_i[4:0]);
  assign ra = AddrWidth'(k_i[4:0] * NumStates + qj_q);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && row_i < NumStates) begin
      if (action_i == ActLeft && col_i < NumStates) left_mem[wr_addr] <= wval_i;
      if (action_i == ActRight && col_i < NumStates) right_mem[wr_addr] <= wval_i;
      if (action_i == ActRate) rate_mem[row_i] <= wval_i;
    end
    if (cmd_i.step && cmd_i.phase == PhRead) begin
      lv_q  <= left_mem[la];
      rv_q  <= right_mem[ra];
      lam_q <= rate_mem[k_i[4:0]];
    end
  end

  // shared multiplier
  logic signed [63:0] ma, mb, prod, qprod;
  always_comb begin
    ma = 64'(lv_q);
    mb = 64'(rv_q);
    case (cmd_i.phase)
      PhLt:   begin ma = 64'(lam_q);  mb = 64'(qt_q); end
      PhExpY: begin ma = 64'(y_q);    mb = 64'(Log2eQ30); end
      PhTe:   begin ma = 64'(term_q); mb = 64'(e_q); end
      PhLam1, PhLam2: begin ma = 64'(term_q); mb = 64'(lam_q); end
      default: ;
    endcase
  end
  assign prod  = ma * mb;
  assign qprod = sat64(prod >>> FracBits);

  // exp fraction step
  logic [63:0] fprod;
  assign fprod = 64'(acc_q) * 64'(pow_tab(m_q));

  logic signed [7:0]  n;
  assign n = y_q[31:24];

  logic [4:0] fbit;
  assign fbit = 5'(5'd24 - m_q);

  logic phase_done;
  always_comb begin
    phase_done = 1'b1;
    if (cmd_i.phase == PhExpF) phase_done = (m_q == 5'd24);
  end
  assign stat_o.phase_done = phase_done;

  logic signed [63:0] lim8, limm32;
  assign lim8   = 64'sd8 <<< FracBits;
  assign limm32 = -(64'sd32 <<< FracBits);
  logic ovf_q, udf_q;
  logic [5:0] shv;
  assign shv = 6'(6 - n);

  logic signed [63:0] s_sat, one, tol, sv;
  assign s_sat = sat64(sum_q);
  assign one   = 64'sd1 <<< FracBits;
  assign tol   = 64'(tol_i);

  // snap near zero or one
  always_comb begin
    sv = s_sat;
    if (sv < 0 && sv > -tol) sv = '0;
    if (sv > one && sv < one + tol) sv = one;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q    <= '0;
      status_q <= StatOk;
    end else if (cmd_i.finish) begin
      if (qneg_q) begin
        res_q <= '0; status_q <= StatNegT;
      end else if (qord_q == 2'd0) begin
        if (sv < 0 || sv > one) begin
          res_q <= '0; status_q <= StatRange;
        end else begin
          res_q <= sv[31:0]; status_q <= StatOk;
        end
      end else begin
        res_q <= s_sat[31:0]; status_q <= StatOk;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      qi_q   <= row_i;
      qj_q   <= col_i;
      qt_q   <= time_i;
      qord_q <= (order_i > 2'd2) ? 2'd2 : order_i;
      qneg_q <= time_i[31];
      qoor_q <= (row_i >= NumStates) || (col_i >= NumStates);
      sum_q  <= '0;
    end else if (cmd_i.step) begin
      case (cmd_i.phase)
        PhLr: term_q <= qprod[31:0];
        PhLt: begin
          y_q   <= qprod[31:0];
          ovf_q <= qprod >= lim8;
          udf_q <= qprod < limm32;
        end
        PhExpY: begin
          y_q   <= 32'(prod >>> 30);
          acc_q <= 32'd1073741824;
          m_q   <= 5'd1;
        end
        PhExpF: begin
          if (y_q[fbit]) acc_q <= 32'(fprod >> 30);
          if (m_q != 5'd24) m_q <= m_q + 1'b1;
        end
        PhExpSh: begin
          if (ovf_q) e_q <= VMax[31:0];
          else if (udf_q) e_q <= '0;
          else if (n >= 8'sd7) e_q <= VMax[31:0];
          else if (shv > 6'd62) e_q <= '0;
          else e_q <= 32'(64'(acc_q) >> shv);
        end
        PhTe, PhLam1, PhLam2: term_q <= qprod[31:0];
        PhAcc: if (!qoor_q && !qneg_q) sum_q <= sum_q + 64'(term_q);
        default: ;
      endcase
    end
  end

  assign res_o    = res_q;
  assign status_o = status_q;
endmodule

### hdl/eigen_transition_probability_top.sv
// Transition probability of a 20-state Markov chain from stored eigenvectors and
// eigenvalues. A query walks the 20 eigen terms through one shared multiplier and
// exp unit; each term passes the read, multiply, exp (with a bit-serial 2^f
// product) and accumulate phases, plus an extra multiply phase for each derivative
// order. The input stays closed while a query runs; with the output free, its result
// word is valid at the edge where the input reopens; a stalled output word holds a
// finished query until it is taken.
// One result word per query, none for writes. depends on etp_pkg, etp_ctrl, etp_datapath
module eigen_transition_probability_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[1:0] row_state[6:2] col_state[11:7] write_value[43:12]
  // branch_time[75:44] deriv_order[77:76]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_value[31:0] status[33:32]
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [24:0] cfg_data_i
);
  import etp_pkg::*;

  logic [TolWidth-1:0] tol_q;
  logic idle, fire, ovalid_q;
  etp_cmd_t  cmd;
  etp_stat_t stat;
  logic [KWidth-1:0] k;
  logic signed [31:0] res;
  logic [1:0] st;

  assign s_axis_tready = idle;
  assign fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q    <= TolReset;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) tol_q <= cfg_data_i;
      if (cmd.finish) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  etp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i (fire),
    .is_query_i(s_axis_tdata[1:0] == ActQuery),
    .out_busy_i(ovalid_q && !m_axis_tready),
    .order_i   (s_axis_tdata[77:76]),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .idle_o    (idle),
    .k_o       (k)
  );

  etp_datapath u_dp (
    .clk_i, .rst_ni,
    .wr_en_i (fire && s_axis_tdata[1:0] != ActQuery),
    .action_i(s_axis_tdata[1:0]),
    .row_i   (s_axis_tdata[6:2]),
    .col_i   (s_axis_tdata[11:7]),
    .wval_i  (s_axis_tdata[43:12]),
    .time_i  (s_axis_tdata[75:44]),
    .order_i (s_axis_tdata[77:76]),
    .tol_i   (tol_q),
    .k_i     (k),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .res_o   (res),
    .status_o(st)
  );

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'd0, st, res};
endmodule
